>>> src/kps_pkg.sv
package kps_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_FRAME = 2'd0;
  localparam logic [1:0] REG_FRAME_TOTAL = 2'd1;

  // Request codes.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Keyframe table size. The 8-bit key index and the 8-bit frame paths are built for it.
  localparam int MAX_KEYS = 256;

  // One item in flight; load items carry their keyframe, queries their result so far.
  typedef struct packed {
    logic        vld;
    logic        load;
    logic        hit;
    logic [7:0]  idx;
    logic [31:0] kx;
    logic [31:0] ky;
    logic [31:0] kz;
    logic [15:0] frac;
    logic [16:0] fade;
  } kps_item_t;

endpackage

>>> src/kps_mod_div.sv
module kps_mod_div #(
  parameter int IPW = 22
) (
  input  logic              clk,
  input  logic              rst,
  input  kps_pkg::kps_item_t i_item,
  input  logic [IPW-1:0]    i_ipart,
  input  logic [7:0]        last,
  output kps_pkg::kps_item_t o_item,
  output logic [7:0]        o_ipart
);

  // Restoring remainder, one dividend bit per stage.
  kps_pkg::kps_item_t item_q [IPW];
  logic [IPW-1:0]     num_q  [IPW];
  logic [7:0]         rem_q  [IPW];

  for (genvar j = 0; j < IPW; j++) begin : g_stage
    kps_pkg::kps_item_t it_in;
    logic [IPW-1:0]     num_in;
    logic [7:0]         rem_in;
    logic [8:0]         trial;
    logic [8:0]         diff;
    logic [7:0]         rem_next;

    if (j == 0) begin : g_first
      assign it_in  = i_item;
      assign num_in = i_ipart;
      assign rem_in = 8'd0;
    end else begin : g_rest
      assign it_in  = item_q[j-1];
      assign num_in = num_q[j-1];
      assign rem_in = rem_q[j-1];
    end

    always_comb begin
      trial = {rem_in, num_in[IPW-1-j]};
      diff  = trial - {1'b0, last};
      if (trial >= {1'b0, last}) begin
        rem_next = diff[7:0];
      end else begin
        rem_next = trial[7:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        item_q[j].vld <= 1'b0;
      end else begin
        item_q[j].vld <= it_in.vld;
      end
      item_q[j].load <= it_in.load;
      item_q[j].hit  <= it_in.hit;
      item_q[j].idx  <= it_in.idx;
      item_q[j].kx   <= it_in.kx;
      item_q[j].ky   <= it_in.ky;
      item_q[j].kz   <= it_in.kz;
      item_q[j].frac <= it_in.frac;
      item_q[j].fade <= it_in.fade;
      num_q[j]       <= num_in;
      rem_q[j]       <= rem_next;
    end
  end

  assign o_item  = item_q[IPW-1];
  assign o_ipart = rem_q[IPW-1];

endmodule

>>> src/kps_fade_div.sv
module kps_fade_div (
  input  logic              clk,
  input  logic              rst,
  input  kps_pkg::kps_item_t i_item,
  input  logic [7:0]        i_ipart,
  input  logic [7:0]        last,
  output kps_pkg::kps_item_t o_item,
  output logic [7:0]        o_ipart
);

  localparam int QW = 17;

  // Quotient (2*frame + last) / (2*last), one quotient bit per stage.
  logic [25:0] num_in;
  logic [8:0]  dvs;

  assign num_in = {1'b0, i_ipart, i_item.frac, 1'b0} + 26'(last);
  assign dvs    = {last, 1'b0};

  kps_pkg::kps_item_t item_q [QW];
  logic [7:0]         ip_q   [QW];
  logic [25:0]        num_q  [QW];
  logic [8:0]         rem_q  [QW];
  logic [QW-1:0]      quo_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    kps_pkg::kps_item_t it_in;
    logic [7:0]         ip_in;
    logic [25:0]        n_in;
    logic [8:0]         rem_in;
    logic [QW-1:0]      quo_in;
    logic [9:0]         trial;
    logic [9:0]         diff;
    logic [8:0]         rem_next;
    logic               qbit;

    if (j == 0) begin : g_first
      assign it_in  = i_item;
      assign ip_in  = i_ipart;
      assign n_in   = num_in;
      assign rem_in = num_in[25:17];
      assign quo_in = '0;
    end else begin : g_rest
      assign it_in  = item_q[j-1];
      assign ip_in  = ip_q[j-1];
      assign n_in   = num_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      trial = {rem_in, n_in[QW-1-j]};
      diff  = trial - {1'b0, dvs};
      qbit  = (trial >= {1'b0, dvs});
      if (qbit) begin
        rem_next = diff[8:0];
      end else begin
        rem_next = trial[8:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        item_q[j].vld <= 1'b0;
      end else begin
        item_q[j].vld <= it_in.vld;
      end
      item_q[j].load <= it_in.load;
      item_q[j].hit  <= it_in.hit;
      item_q[j].idx  <= it_in.idx;
      item_q[j].kx   <= it_in.kx;
      item_q[j].ky   <= it_in.ky;
      item_q[j].kz   <= it_in.kz;
      item_q[j].frac <= it_in.frac;
      item_q[j].fade <= it_in.fade;
      ip_q[j]        <= ip_in;
      num_q[j]       <= n_in;
      rem_q[j]       <= rem_next;
      quo_q[j]       <= {quo_in[QW-2:0], qbit};
    end
  end

  always_comb begin
    o_item      = item_q[QW-1];
    o_item.fade = 17'd65536 - quo_q[QW-1];
  end
  assign o_ipart = ip_q[QW-1];

endmodule

>>> src/kps_interp.sv
module kps_interp (
  input  logic               clk,
  input  logic               rst,
  input  kps_pkg::kps_item_t i_item,
  input  logic [7:0]         i_addr,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [16:0]        fade_level
);

  localparam int DEPTH = kps_pkg::MAX_KEYS;
  localparam int AW    = $clog2(DEPTH);

  logic [95:0] mem [DEPTH];

  logic [7:0]  addr1;
  logic        wr_en;

  assign addr1 = i_addr + 8'd1;
  assign wr_en = i_item.vld && (i_item.load == kps_pkg::REQ_LOAD) &&
                 (32'(i_item.idx) < kps_pkg::MAX_KEYS);

  // Read stage. Loads write here too, so they stay ordered with the queries.
  kps_pkg::kps_item_t item_r;
  logic [95:0]        p0_r;
  logic [95:0]        p1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[i_item.idx[AW-1:0]] <= {i_item.kx, i_item.ky, i_item.kz};
    end
    p0_r <= mem[i_addr[AW-1:0]];
    p1_r <= mem[addr1[AW-1:0]];
  end

  // Difference, multiply and sum stages, one lane per axis.
  kps_pkg::kps_item_t item_d;
  kps_pkg::kps_item_t item_m;
  logic signed [32:0] d_q  [3];
  logic signed [31:0] p0_d [3];
  logic signed [49:0] m_q  [3];
  logic signed [31:0] p0_m [3];
  logic signed [31:0] v_q  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      item_r.vld <= 1'b0;
      item_d.vld <= 1'b0;
      item_m.vld <= 1'b0;
      done       <= 1'b0;
    end else begin
      item_r.vld <= i_item.vld;
      item_d.vld <= item_r.vld;
      item_m.vld <= item_d.vld;
      done       <= item_m.vld && (item_m.load != kps_pkg::REQ_LOAD);
    end
    item_r.load <= i_item.load;
    item_r.hit  <= i_item.hit;
    item_r.idx  <= i_item.idx;
    item_r.kx   <= i_item.kx;
    item_r.ky   <= i_item.ky;
    item_r.kz   <= i_item.kz;
    item_r.frac <= i_item.frac;
    item_r.fade <= i_item.fade;
    item_d.load <= item_r.load;
    item_d.hit  <= item_r.hit;
    item_d.idx  <= item_r.idx;
    item_d.kx   <= item_r.kx;
    item_d.ky   <= item_r.ky;
    item_d.kz   <= item_r.kz;
    item_d.frac <= item_r.frac;
    item_d.fade <= item_r.fade;
    item_m.load <= item_d.load;
    item_m.hit  <= item_d.hit;
    item_m.idx  <= item_d.idx;
    item_m.kx   <= item_d.kx;
    item_m.ky   <= item_d.ky;
    item_m.kz   <= item_d.kz;
    item_m.frac <= item_d.frac;
    item_m.fade <= item_d.fade;
    hit         <= item_m.hit;
    fade_level  <= item_m.hit ? item_m.fade : 17'd0;
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [31:0] p0_w;
    logic signed [31:0] p1_w;
    logic signed [49:0] rnd;

    assign p0_w = $signed(p0_r[95-32*k -: 32]);
    assign p1_w = $signed(p1_r[95-32*k -: 32]);
    assign rnd  = (m_q[k] + 50'sd32768) >>> 16;

    always_ff @(posedge clk) begin
      d_q[k]  <= 33'(p1_w) - 33'(p0_w);
      p0_d[k] <= p0_w;
      m_q[k]  <= 50'(d_q[k]) * $signed({34'd0, item_d.frac});
      p0_m[k] <= p0_d[k];
      v_q[k]  <= item_m.hit ? (p0_m[k] + rnd[31:0]) : 32'sd0;
    end
  end

  assign out_x = v_q[0];
  assign out_y = v_q[1];
  assign out_z = v_q[2];

endmodule

>>> src/keyframe_position_sampler_core.sv
// Channel   | Ports                                              | Beat
// ----------+----------------------------------------------------+-------------------------
// request   | start, busy, req_type, key_index, key_x/y/z,       | start high, busy low
//           | sample_time, wrap_enable                           |
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data          | cfg_valid and cfg_ready
// result    | done, hit, out_x/y/z, fade_level                   | done high, one cycle
//
// One request beat is taken every cycle; busy stays low. A query's result comes out
// of the interpolator after the stage registers and the two bit-per-stage dividers:
// the wrap remainder and the fade quotient. Loads give no result. Reset (rst, synchronous)
// clears the valid bits and the configuration registers; the keyframe table is not
// cleared. The receiver cannot stall, so nothing in the pipeline ever waits.
module keyframe_position_sampler_core #(
  parameter int FRAMES_PER_SECOND = 50
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [7:0]         key_index,
  input  logic signed [31:0] key_x,
  input  logic signed [31:0] key_y,
  input  logic signed [31:0] key_z,
  input  logic signed [31:0] sample_time,
  input  logic               wrap_enable,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [16:0]        fade_level
);

  // Frame width: time times the rate needs the multiplier bits plus room for the
  // start frame subtraction. The integer frame part is what remains above 16 bits.
  localparam int MULW = $clog2(FRAMES_PER_SECOND + 1);
  localparam int FRW  = 32 + MULW + 1;
  localparam int IPW  = FRW - 17;
  localparam int LAT  = 3 + IPW + 17 + 4;

  localparam logic signed [FRW-1:0] FPS_S = FRW'(FRAMES_PER_SECOND);

  // Configuration is taken at any time; the user must change it only while idle; no check.
  logic [15:0] start_frame;
  logic [8:0]  frame_total;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_frame <= 16'd0;
      frame_total <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        kps_pkg::REG_START_FRAME: start_frame <= cfg_data;
        kps_pkg::REG_FRAME_TOTAL: frame_total <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Table size is capped at the table depth; last is the index of the final keyframe.
  logic [8:0] cnt;
  logic [8:0] last_w;
  logic [7:0] last;
  logic       too_few;

  assign cnt     = (32'(frame_total) > kps_pkg::MAX_KEYS) ? 9'(kps_pkg::MAX_KEYS) :
                   frame_total;
  assign last_w  = cnt - 9'd1;
  assign last    = last_w[7:0];
  assign too_few = (cnt < 9'd2);

  // Stage 0: capture the beat.
  kps_pkg::kps_item_t s0_item;
  logic [31:0]        s0_time;
  logic               s0_wrap;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_item.vld <= 1'b0;
    end else begin
      s0_item.vld <= start && !busy;
    end
    s0_item.load <= req_type;
    s0_item.hit  <= 1'b0;
    s0_item.idx  <= key_index;
    s0_item.kx   <= key_x;
    s0_item.ky   <= key_y;
    s0_item.kz   <= key_z;
    s0_item.frac <= 16'd0;
    s0_item.fade <= 17'd0;
    s0_time      <= sample_time;
    s0_wrap      <= wrap_enable;
  end

  // Stage 1: frame number in Q.16.
  kps_pkg::kps_item_t     s1_item;
  logic signed [FRW-1:0]  s1_frame;
  logic                   s1_wrap;
  logic signed [FRW-1:0]  tm_ext;
  logic signed [FRW-1:0]  sf_ext;

  assign tm_ext = FRW'($signed(s0_time));
  assign sf_ext = $signed(FRW'({start_frame, 16'd0}));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_item.vld <= 1'b0;
    end else begin
      s1_item.vld <= s0_item.vld;
    end
    s1_item.load <= s0_item.load;
    s1_item.hit  <= s0_item.hit;
    s1_item.idx  <= s0_item.idx;
    s1_item.kx   <= s0_item.kx;
    s1_item.ky   <= s0_item.ky;
    s1_item.kz   <= s0_item.kz;
    s1_item.frac <= s0_item.frac;
    s1_item.fade <= s0_item.fade;
    s1_frame     <= tm_ext * FPS_S - sf_ext;
    s1_wrap      <= s0_wrap;
  end

  // Stage 2: range checks. A frame below last needs no wrap, and its remainder
  // modulo last is itself, so every query goes through the remainder pipe.
  kps_pkg::kps_item_t s2_item;
  logic [IPW-1:0]     s2_ipart;
  logic [IPW-1:0]     ipart_w;
  logic               past_end;
  logic               hit_w;

  assign ipart_w  = s1_frame[FRW-2:16];
  assign past_end = (ipart_w >= IPW'(last));
  assign hit_w    = !s1_frame[FRW-1] && !too_few && (!past_end || s1_wrap);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_item.vld <= 1'b0;
    end else begin
      s2_item.vld <= s1_item.vld;
    end
    s2_item.load <= s1_item.load;
    s2_item.hit  <= hit_w;
    s2_item.idx  <= s1_item.idx;
    s2_item.kx   <= s1_item.kx;
    s2_item.ky   <= s1_item.ky;
    s2_item.kz   <= s1_item.kz;
    s2_item.frac <= s1_frame[15:0];
    s2_item.fade <= s1_item.fade;
    s2_ipart     <= ipart_w;
  end

  kps_pkg::kps_item_t md_item;
  logic [7:0]         md_ipart;
  kps_pkg::kps_item_t fd_item;
  logic [7:0]         fd_ipart;

  kps_mod_div #(
    .IPW (IPW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .i_item  (s2_item),
    .i_ipart (s2_ipart),
    .last    (last),
    .o_item  (md_item),
    .o_ipart (md_ipart)
  );

  kps_fade_div u_fade (
    .clk     (clk),
    .rst     (rst),
    .i_item  (md_item),
    .i_ipart (md_ipart),
    .last    (last),
    .o_item  (fd_item),
    .o_ipart (fd_ipart)
  );

  kps_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .i_item     (fd_item),
    .i_addr     (fd_ipart),
    .done       (done),
    .hit        (hit),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .fade_level (fade_level)
  );

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (out_x == 32'sd0 && out_y == 32'sd0 && out_z == 32'sd0 &&
                        fade_level == 17'd0))
    else $error("miss result carries nonzero data");

  a_fade_range: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (fade_level <= 17'd65536))
    else $error("fade level out of range");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (req_type == kps_pkg::REQ_SAMPLE), LAT))
    else $error("result without a matching query");
`endif

endmodule

>>> sim/keyframe_position_sampler_core_test.sv
module keyframe_position_sampler_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  // The settle time covers a query result's trip and leaves margin for in-flight loads.
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 4000;
  localparam int TABLE_DEPTH   = 256;

  typedef struct {
    logic               hit;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [16:0]        fade;
  } sample_t;

  // Keeps its own copy of the keyframe table and the two registers, computes the
  // sample that each accepted query must produce and holds it until it arrives.
  class sample_scoreboard;
    longint    keys [TABLE_DEPTH][3];
    bit [15:0] first_frame;
    bit [8:0]  key_count;
    sample_t   due_samples [$];
    int        errors;

    function void note_config(logic [1:0] idx, logic [15:0] data);
      if (idx == kps_pkg::REG_START_FRAME) begin
        first_frame = data;
      end else if (idx == kps_pkg::REG_FRAME_TOTAL) begin
        key_count = data[8:0];
      end
    endfunction

    function void note_item(logic kind, logic [7:0] idx, logic signed [31:0] kx,
                            logic signed [31:0] ky, logic signed [31:0] kz,
                            logic signed [31:0] t, logic wrap);
      sample_t s;
      longint  frame, ipart, frac, last, cnt, p0, p1, v, fq, q;
      s = '{hit: 1'b0, x: '0, y: '0, z: '0, fade: '0};
      if (kind == kps_pkg::REQ_LOAD) begin
        keys[idx][0] = longint'(kx);
        keys[idx][1] = longint'(ky);
        keys[idx][2] = longint'(kz);
        return;
      end
      cnt = (key_count > TABLE_DEPTH) ? TABLE_DEPTH : longint'(key_count);
      frame = longint'(t) * 50 - (longint'(first_frame) <<< 16);
      if (cnt < 2 || frame < 0) begin
        due_samples.push_back(s);
        return;
      end
      last  = cnt - 1;
      ipart = frame >>> 16;
      frac  = frame & 64'hFFFF;
      if (ipart >= last) begin
        if (!wrap) begin
          due_samples.push_back(s);
          return;
        end
        ipart = ipart % last;
      end
      s.hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        p0 = keys[ipart][k];
        p1 = keys[ipart + 1][k];
        v  = p0 + (((p1 - p0) * frac + 32768) >>> 16);
        if (k == 0) s.x = v[31:0];
        else if (k == 1) s.y = v[31:0];
        else s.z = v[31:0];
      end
      fq = (ipart <<< 16) | frac;
      q  = (2 * fq + last) / (2 * last);
      if (q > 65536) q = 65536;
      s.fade = 17'(65536 - q);
      due_samples.push_back(s);
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (due_samples.size() == 0) begin
        $display("%0t: unexpected result hit=%0d x=%0d y=%0d z=%0d fade=%0d",
                 $time, got.hit, got.x, got.y, got.z, got.fade);
        errors++;
        return;
      end
      want = due_samples.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
        errors++;
      end
      if (got.x !== want.x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.z !== want.z) begin
        $display("%0t: out_z expected %0d actual %0d", $time, want.z, got.z);
        errors++;
      end
      if (got.fade !== want.fade) begin
        $display("%0t: fade_level expected %0d actual %0d", $time, want.fade, got.fade);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               req_type = kps_pkg::REQ_LOAD;
  logic [7:0]         key_index = '0;
  logic signed [31:0] key_x = '0;
  logic signed [31:0] key_y = '0;
  logic signed [31:0] key_z = '0;
  logic signed [31:0] sample_time = '0;
  logic               wrap_enable = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               done;
  logic               hit;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [16:0]        fade_level;

  sample_scoreboard board = new();
  int  stall_cycles = 0;
  bit  no_gaps = 1'b0;
  // Register values of the current phase, used to aim query times at the sequence.
  int  cur_start = 0;
  int  cur_total = 0;

  keyframe_position_sampler_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .key_index(key_index), .key_x(key_x), .key_y(key_y), .key_z(key_z),
    .sample_time(sample_time), .wrap_enable(wrap_enable), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .hit(hit), .out_x(out_x), .out_y(out_y), .out_z(out_z), .fade_level(fade_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every beat is observed here, at the edge that moves it. Inputs change only by
  // nonblocking assignment, so the values seen are the ones the block samples too.
  // The watchdog counts cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_item(req_type, key_index, key_x, key_y, key_z, sample_time, wrap_enable);
      end
      if (cfg_valid && cfg_ready) begin
        board.note_config(cfg_index, cfg_data);
      end
      if (done) begin
        board.check_sample('{hit: hit, x: out_x, y: out_y, z: out_z, fade: fade_level});
      end
      if ((start && !busy) || (cfg_valid && cfg_ready) || done) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Mostly back to back, some short pauses, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drives one request beat after an optional pause and waits until it is taken.
  // start is left high so that the next beat can follow without a dead cycle.
  task automatic send_item(logic kind, logic [7:0] idx, logic signed [31:0] kx,
                           logic signed [31:0] ky, logic signed [31:0] kz,
                           logic signed [31:0] t, logic wrap);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= kind;
    key_index   <= idx;
    key_x       <= kx;
    key_y       <= ky;
    key_z       <= kz;
    sample_time <= t;
    wrap_enable <= wrap;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_load(logic [7:0] idx, logic signed [31:0] kx,
                           logic signed [31:0] ky, logic signed [31:0] kz);
    send_item(kps_pkg::REQ_LOAD, idx, kx, ky, kz, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_query(logic signed [31:0] t, logic wrap);
    send_item(kps_pkg::REQ_SAMPLE, 8'($urandom), $urandom, $urandom, $urandom, t, wrap);
  endtask

  // Query time that lands on or just after a given frame position (Q.16, relative
  // to start_frame); the time is rounded up for positions at or after the start.
  function automatic logic signed [31:0] time_at(longint frame_q16);
    return 32'((longint'(cur_start) * 65536 + frame_q16 + 49) / 50);
  endfunction

  // The first negedge lets the monitor note a beat taken at the last edge.
  task automatic wait_drained();
    @(negedge clk);
    while (board.due_samples.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty: all results in and loads settled.
  task automatic set_registers(int first, int total);
    start <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= kps_pkg::REG_START_FRAME;
    cfg_data  <= 16'(first);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= kps_pkg::REG_FRAME_TOTAL;
    cfg_data  <= 16'(total);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // A write to an undecoded index must not disturb either register.
    cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_start = first;
    cur_total = (total[8:0] > TABLE_DEPTH) ? TABLE_DEPTH : int'(total[8:0]);
  endtask

  // Random traffic for one phase: mostly queries aimed at and around the sequence,
  // some fully random times, and keyframe reloads mixed in.
  task automatic run_phase(int count);
    int  last, r;
    longint span;
    last = (cur_total > 1) ? cur_total - 1 : 1;
    span = longint'(last + 3) * 65536;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i == count / 2) begin
        // Let the pipeline run dry once before carrying on.
        start <= 1'b0;
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_load(8'($urandom), $urandom, $urandom, $urandom);
      end else if (r < 30) begin
        send_query($urandom, 1'($urandom_range(0, 1)));
      end else begin
        send_query(time_at(longint'($urandom_range(0, 32'(span))) - 65536),
                   1'($urandom_range(0, 1)));
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table first so that no query ever reads an unwritten entry.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_load(8'(i), $urandom, $urandom, $urandom);
    end

    // Too few frames: every query misses, whatever its time.
    set_registers(0, 0);
    send_query(0, 1'b1);
    send_query(32'sd65536, 1'b0);
    set_registers(0, 1);
    send_query(0, 1'b1);
    send_query(32'sh7fffffff, 1'b1);

    // Directed cases on a short sequence with extreme keyframe values.
    set_registers(0, 4);
    send_load(0, 32'sh80000000, 32'sh7fffffff, 0);
    send_load(1, 32'sh7fffffff, 32'sh80000000, 32'shffffffff);
    send_load(2, 0, 32'sh7fffffff, 32'sh80000000);
    send_load(3, 32'sh00010000, 32'shffff0000, 32'sh7fffffff);
    send_query(0, 1'b0);                        // first keyframe exactly
    send_query(32'sd16384, 1'b1);                // halfway after wrapping, rounding tie
    send_query(time_at(65536 + 1), 1'b0);        // just past a keyframe
    send_query(time_at(3 * 65536 - 50), 1'b0);   // just short of the last frame
    send_query(time_at(3 * 65536), 1'b0);        // at the last frame, no wrap: miss
    send_query(time_at(3 * 65536), 1'b1);        // at the last frame, wrapped
    send_query(time_at(7 * 65536 + 40000), 1'b1); // far past the end, wrapped
    send_query(-1, 1'b1);                        // negative time
    send_query(32'sh80000000, 1'b1);             // most negative time
    send_query(32'sh7fffffff, 1'b1);             // largest time, wrapped
    send_query(32'sh7fffffff, 1'b0);             // largest time, no wrap

    // Start frame pushes small times below the sequence; count at its maximum.
    set_registers(65535, 256);
    send_query(32'sh7fffffff, 1'b1);
    send_query(time_at(-1), 1'b1);
    send_query(time_at(0), 1'b0);
    run_phase(200);

    // A count above the table size is clipped to the table.
    set_registers(100, 16'hffff);
    run_phase(200);
    set_registers(0, 2);
    run_phase(250);
    set_registers(0, 256);
    run_phase(250);
    set_registers(65535, 3);
    run_phase(200);
    for (int p = 0; p < 3; p++) begin
      set_registers($urandom_range(0, 65535), $urandom_range(0, 300));
      run_phase(200);
    end

    start <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.due_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> keyframe_position_sampler_core.f
src/kps_pkg.sv
src/kps_mod_div.sv
src/kps_fade_div.sv
src/kps_interp.sv
src/keyframe_position_sampler_core.sv
sim/keyframe_position_sampler_core_test.sv
